[rtl/core/sector_cache_clock_replacement_unit_macros.svh]
// Assertion macros shared by the sector cache clock replacement unit.
// Included by the controller, which carries the concurrent assertions; no other dependencies.
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_UNIT_MACROS_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/scc_pkg.sv]
// Shared types and constants of the sector cache clock replacement unit.
// No dependencies; imported by the controller, the datapath and the top level.
package scc_pkg;

    localparam int NUM_SLOTS    = 8;
    localparam int SLOT_BITS    = 3;
    localparam int SECTOR_BITS  = 24;
    localparam int SWEEP_FACTOR = 2;
    localparam int SWEEP_LEN    = SWEEP_FACTOR * NUM_SLOTS;
    localparam int CNT_BITS     = $clog2(SWEEP_LEN);
    localparam int CMD_BITS     = 3;
    localparam int STATUS_BITS  = 2;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 32;

    // Request commands.
    typedef enum logic [CMD_BITS-1:0] {
        CMD_READ  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_PIN   = 3'd2,
        CMD_UNPIN = 3'd3,
        CMD_FLUSH = 3'd4
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        STS_HIT       = 2'd0,
        STS_FILLED    = 2'd1,
        STS_ALLPINNED = 2'd2,
        STS_NOTFOUND  = 2'd3
    } t_status;

    // Kind of result item that the datapath loads into the output register.
    typedef enum logic [2:0] {
        EM_ZERO       = 3'd0,
        EM_HIT        = 3'd1,
        EM_NOTFOUND   = 3'd2,
        EM_ALLPINNED  = 3'd3,
        EM_VICTIM     = 3'd4,
        EM_FLUSH_ITEM = 3'd5
    } t_emit_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       emit;
        t_emit_kind kind;
        logic       sweep_start;
        logic       flush_start;
        logic       step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic                hit;
        logic                victim;
        logic                sweep_end;
        logic                flush_mod;
        logic                flush_last;
        logic                mod_none;
        logic                out_free;
    } t_dp_sts;

endpackage

[rtl/core/sector_cache_clock_replacement_unit.sv]
// A hit or unpin result is loaded into the output register from the lookup state once the
// output register is free. Flush with no modified slot gives a single zero item.
// A miss sweeps the clock hand, at most 16 steps; all slots pinned gives an all-pinned result.
// Flush scans a slot per cycle from slot 0, held by a full output; one item per modified slot.
// Throughput: one request at a time; the next is taken the cycle after the last item is loaded.
// Reset: synchronous, active low; all slots unallocated and marked, hand at slot 0, no result.
module sector_cache_clock_replacement_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [scc_pkg::IN_DATA_W-1:0]  i_s_tdata,  // [23:0] sector
    input  logic [scc_pkg::CMD_BITS-1:0]   i_s_tuser,  // [2:0] command
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [scc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // [1:0] status, [4:2] slot, [5] writeback_valid, [29:6] writeback_sector,
    // [30] fill_valid, [31] zero
    output logic                           o_m_tlast
);
    import scc_pkg::*;

    t_dp_cmd ctl;
    t_dp_sts sts;

    // Request sequencing.
    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // Tags, flags and result register.
    scc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_in    (i_s_tuser),
        .i_sector_in (i_s_tdata),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

[rtl/core/scc_datapath.sv]
// Datapath of the sector cache clock replacement unit: tag store, slot flags,
// clock hand, sweep and scan index, and the result output register. Uses scc_pkg.
module scc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [scc_pkg::CMD_BITS-1:0]  i_cmd_in,
    input  logic [scc_pkg::IN_DATA_W-1:0] i_sector_in,
    input  scc_pkg::t_dp_cmd              i_ctl,
    output scc_pkg::t_dp_sts              o_sts,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [scc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast
);
    import scc_pkg::*;

    // Slot state.
    logic [SECTOR_BITS-1:0] r_tag [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_unalloc;
    logic [NUM_SLOTS-1:0]   r_repl;
    logic [NUM_SLOTS-1:0]   r_pinned;
    logic [NUM_SLOTS-1:0]   r_mod;
    logic [SLOT_BITS-1:0]   r_hand;

    // Request and walk registers.
    logic [CMD_BITS-1:0]    r_cmd;
    logic [SECTOR_BITS-1:0] r_sector;
    logic [SLOT_BITS-1:0]   r_idx;
    logic [CNT_BITS-1:0]    r_cnt;

    // Output register.
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic                   r_out_last;

    logic                   hit;
    logic [SLOT_BITS-1:0]   hit_idx;
    logic                   above_mod;
    logic [SLOT_BITS-1:0]   idx_inc;
    logic [SECTOR_BITS-1:0] cur_tag;
    logic                   out_free;

    t_status                e_status;
    logic [SLOT_BITS-1:0]   e_slot;
    logic                   e_wbv;
    logic [SECTOR_BITS-1:0] e_wbsec;
    logic                   e_fill;
    logic                   e_last;

    // Lookup: lowest allocated slot whose tag matches the requested sector.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_unalloc[i] && (r_tag[i] == r_sector)) begin
                hit     = 1'b1;
                hit_idx = SLOT_BITS'(i);
            end
        end
    end

    // A modified slot above the scan index means this flush item is not the final one.
    always_comb begin
        above_mod = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if ((SLOT_BITS'(j) > r_idx) && r_mod[j]) begin
                above_mod = 1'b1;
            end
        end
    end

    assign idx_inc  = (r_idx == SLOT_BITS'(NUM_SLOTS - 1)) ? '0 : r_idx + 1'b1;
    assign cur_tag  = r_tag[r_idx];
    assign out_free = !r_out_valid || i_m_tready;

    // Status towards the controller.
    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.hit        = hit;
        o_sts.victim     = r_repl[r_idx] && !r_pinned[r_idx];
        o_sts.sweep_end  = (r_cnt == CNT_BITS'(SWEEP_LEN - 1));
        o_sts.flush_mod  = r_mod[r_idx];
        o_sts.flush_last = !above_mod;
        o_sts.mod_none   = (r_mod == '0);
        o_sts.out_free   = out_free;
    end

    // Fields of the result item about to be emitted.
    always_comb begin
        e_status = STS_HIT;
        e_slot   = '0;
        e_wbv    = 1'b0;
        e_wbsec  = '0;
        e_fill   = 1'b0;
        e_last   = 1'b1;
        case (i_ctl.kind)
            EM_HIT: begin
                e_slot = hit_idx;
            end
            EM_NOTFOUND: begin
                e_status = STS_NOTFOUND;
            end
            EM_ALLPINNED: begin
                e_status = STS_ALLPINNED;
            end
            EM_VICTIM: begin
                e_status = STS_FILLED;
                e_slot   = r_idx;
                e_wbv    = r_mod[r_idx];
                e_wbsec  = r_mod[r_idx] ? cur_tag : '0;
                e_fill   = 1'b1;
            end
            EM_FLUSH_ITEM: begin
                e_slot  = r_idx;
                e_wbv   = 1'b1;
                e_wbsec = cur_tag;
                e_last  = !above_mod;
            end
            default: begin
                e_last = 1'b1;
            end
        endcase
    end

    // Request capture, walk index and sweep counter.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd    <= i_cmd_in;
            r_sector <= i_sector_in[SECTOR_BITS-1:0];
        end
        if (i_ctl.sweep_start) begin
            r_idx <= r_hand;
            r_cnt <= '0;
        end else if (i_ctl.flush_start) begin
            r_idx <= '0;
        end else if (i_ctl.step) begin
            r_idx <= idx_inc;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Tag store: written only when a victim takes the new sector.
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit && (i_ctl.kind == EM_VICTIM)) begin
            r_tag[r_idx] <= r_sector;
        end
    end

    // Slot flags and clock hand.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unalloc <= '1;
            r_repl    <= '1;
            r_pinned  <= '0;
            r_mod     <= '0;
            r_hand    <= '0;
        end else begin
            if (i_ctl.emit && (i_ctl.kind == EM_HIT)) begin
                case (r_cmd)
                    CMD_READ: begin
                        r_repl[hit_idx] <= 1'b0;
                    end
                    CMD_WRITE: begin
                        r_repl[hit_idx] <= 1'b0;
                        r_mod[hit_idx]  <= 1'b1;
                    end
                    CMD_PIN: begin
                        r_pinned[hit_idx] <= 1'b1;
                    end
                    CMD_UNPIN: begin
                        r_pinned[hit_idx] <= 1'b0;
                    end
                    default: begin
                        r_hand <= r_hand;
                    end
                endcase
            end else if (i_ctl.emit && (i_ctl.kind == EM_VICTIM)) begin
                r_unalloc[r_idx] <= 1'b0;
                r_repl[r_idx]    <= 1'b0;
                r_pinned[r_idx]  <= (r_cmd == CMD_PIN);
                r_mod[r_idx]     <= (r_cmd == CMD_WRITE) || (r_cmd == CMD_PIN);
                r_hand           <= r_idx;
            end else if (i_ctl.step && i_ctl.sweep_start == 1'b0 && !r_repl[r_idx]
                         && (r_cmd != CMD_FLUSH)) begin
                // A sweep step gives an unmarked slot its second chance.
                r_repl[r_idx] <= 1'b1;
            end
        end
    end

    // Output register: loads a result when the previous one is taken or absent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_data <= {1'b0, e_fill, e_wbsec, e_wbv, e_slot, e_status};
            r_out_last <= e_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

[rtl/core/scc_ctrl.sv]
// Controller of the sector cache clock replacement unit: the request state machine
// that sequences lookup, clock sweep and flush scan. Uses scc_pkg and the macro header.
`include "sector_cache_clock_replacement_unit_macros.svh"

module scc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  scc_pkg::t_dp_sts i_sts,
    output scc_pkg::t_dp_cmd o_ctl
);
    import scc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_SWEEP  = 5'b00100,
        ST_FAIL   = 5'b01000,
        ST_FLUSH  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state           = r_state;
        o_ctl.capture     = 1'b0;
        o_ctl.emit        = 1'b0;
        o_ctl.kind        = EM_ZERO;
        o_ctl.sweep_start = 1'b0;
        o_ctl.flush_start = 1'b0;
        o_ctl.step        = 1'b0;
        o_s_tready        = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                case (i_sts.cmd)
                    CMD_READ, CMD_WRITE, CMD_PIN: begin
                        if (!i_sts.hit) begin
                            o_ctl.sweep_start = 1'b1;
                            n_state           = ST_SWEEP;
                        end else if (i_sts.out_free) begin
                            o_ctl.emit = 1'b1;
                            o_ctl.kind = EM_HIT;
                            n_state    = ST_IDLE;
                        end
                    end
                    CMD_UNPIN: begin
                        if (i_sts.out_free) begin
                            o_ctl.emit = 1'b1;
                            o_ctl.kind = i_sts.hit ? EM_HIT : EM_NOTFOUND;
                            n_state    = ST_IDLE;
                        end
                    end
                    CMD_FLUSH: begin
                        if (!i_sts.mod_none) begin
                            o_ctl.flush_start = 1'b1;
                            n_state           = ST_FLUSH;
                        end else if (i_sts.out_free) begin
                            o_ctl.emit = 1'b1;
                            o_ctl.kind = EM_ZERO;
                            n_state    = ST_IDLE;
                        end
                    end
                    default: begin
                        // Unused command codes give a single empty item.
                        if (i_sts.out_free) begin
                            o_ctl.emit = 1'b1;
                            o_ctl.kind = EM_ZERO;
                            n_state    = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SWEEP: begin
                if (i_sts.victim) begin
                    if (i_sts.out_free) begin
                        o_ctl.emit = 1'b1;
                        o_ctl.kind = EM_VICTIM;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    o_ctl.step = 1'b1;
                    if (i_sts.sweep_end) begin
                        n_state = ST_FAIL;
                    end
                end
            end
            ST_FAIL: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = EM_ALLPINNED;
                    n_state    = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!i_sts.flush_mod) begin
                    o_ctl.step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.kind = EM_FLUSH_ITEM;
                    if (i_sts.flush_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_ctl.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A result is only loaded when the output register can take it.
    `SCC_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, o_ctl.emit, i_sts.out_free, "emit while output full")
    // A captured request is looked up in the next cycle.
    `SCC_ASSERT_NEXT(a_capture_lookup, i_clk, i_rst_n, o_ctl.capture, r_state == ST_LOOKUP, "capture not followed by lookup")
    // An installed victim ends the request.
    `SCC_ASSERT_NEXT(a_victim_done, i_clk, i_rst_n, o_ctl.emit && (o_ctl.kind == EM_VICTIM), r_state == ST_IDLE, "victim did not end request")

endmodule
